// ===== hw/rtl/tactile_slip_detector_defines.svh =====
// ----------------------------------------------------------------------------
// Tactile slip detector assertion macros
// Shared helpers for the concurrent checks, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef TACTILE_SLIP_DETECTOR_DEFINES_SVH
`define TACTILE_SLIP_DETECTOR_DEFINES_SVH

// same-cycle implication
`define TSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Tactile slip detector package
// Widths, codes, payload and control types shared by the detector modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsd_pkg;

    localparam int TAXELS_DEFAULT       = 22;
    localparam int WINDOW_DEPTH_DEFAULT = 5;

    localparam int INDEX_W     = 5;
    localparam int SAMPLE_W    = 16;
    localparam int CORR_W      = 17;
    localparam int SLOPE_W     = 18;
    localparam int ACC_W       = 24;
    localparam int SUM_W       = 20;
    localparam int SLOT_W      = 3;
    localparam int FRAMES_W    = 8;
    localparam int THR_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int DIV_CNT_W   = 5;

    // divider sweep: load, one step per dividend bit, store
    localparam logic [DIV_CNT_W-1:0] DIV_LOAD  = 5'd0;
    localparam logic [DIV_CNT_W-1:0] DIV_STORE = 5'd25;

    localparam logic [CFG_INDEX_W-1:0] REG_AMP_THRESHOLD      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLIP_THRESHOLD     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CALIBRATION_FRAMES = 2'd2;

    localparam logic [THR_W-1:0]    AMP_THR_RESET    = 16'd2000;
    localparam logic [THR_W-1:0]    SLIP_THR_RESET   = 16'd75;
    localparam logic [FRAMES_W-1:0] CAL_FRAMES_RESET = 8'd20;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX       = 8'd255;

    localparam logic signed [SLOPE_W-1:0] LOW_SLOPE_RESET  = 18'sd30000;
    localparam logic signed [SLOPE_W-1:0] HIGH_SLOPE_RESET = -18'sd30000;

    localparam logic signed [CORR_W-1:0] BAND1_HIGH = 17'sd4000;
    localparam logic signed [CORR_W-1:0] BAND2_LOW  = 17'sd4001;
    localparam logic signed [CORR_W-1:0] BAND2_HIGH = 17'sd6000;
    localparam logic signed [CORR_W-1:0] BAND3_LOW  = 17'sd8001;
    localparam logic signed [CORR_W-1:0] BAND3_HIGH = 17'sd12000;

    localparam logic signed [ACC_W:0] OFFSET_MAX = 25'sd32767;
    localparam logic signed [ACC_W:0] OFFSET_MIN = -25'sd32768;

    localparam logic [1:0] DRIVE_OFF   = 2'd0;
    localparam logic [1:0] DRIVE_ON    = 2'd1;
    localparam logic [1:0] DRIVE_PULSE = 2'd2;

    localparam logic [1:0] AMP_MEDIUM = 2'd0;
    localparam logic [1:0] AMP_LOW    = 2'd1;
    localparam logic [1:0] AMP_MID    = 2'd2;
    localparam logic [1:0] AMP_HIGH   = 2'd3;

    typedef struct packed {
        logic [INDEX_W-1:0]         taxel_index;
        logic signed [SAMPLE_W-1:0] right_finger_sample;
        logic signed [SAMPLE_W-1:0] left_finger_sample;
        logic                       frame_last;
    } tsd_sample_t;

    typedef struct packed {
        logic       calibrated;
        logic [1:0] right_drive;
        logic [1:0] right_amplitude;
        logic [1:0] left_drive;
        logic [1:0] left_amplitude;
    } tsd_report_t;

    typedef struct packed {
        logic [1:0] right_drive;
        logic [1:0] right_amplitude;
        logic [1:0] left_drive;
        logic [1:0] left_amplitude;
    } tsd_levels_t;

    typedef struct packed {
        logic rd_en;
        logic acc_en;
        logic sum_en;
        logic scale_en;
        logic stats_en;
        logic clear_en;
        logic div_load;
        logic div_step;
        logic div_store;
    } lane_ctl_t;

    typedef struct packed {
        logic signed [CORR_W-1:0]  peak;
        logic signed [SLOPE_W-1:0] low;
        logic signed [SLOPE_W-1:0] high;
    } lane_stats_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_SUM,
        ST_SCALE,
        ST_STATS,
        ST_FRAME,
        ST_DIVIDE,
        ST_EMIT
    } tsd_state_t;

endpackage

// ===== hw/rtl/tsd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/tsd_lane.sv =====
// ----------------------------------------------------------------------------
// Tactile slip detector finger lane
// Per-finger offsets, window store, mean and slope tracking, offset divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsd_lane #(
    parameter int TAXELS       = tsd_pkg::TAXELS_DEFAULT,
    parameter int WINDOW_DEPTH = tsd_pkg::WINDOW_DEPTH_DEFAULT,
    localparam int TW = (TAXELS > 1) ? $clog2(TAXELS) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tsd_pkg::lane_ctl_t                   ctl,
    input  logic [TW-1:0]                        rd_tx,
    input  logic [TW-1:0]                        tx,
    input  logic [tsd_pkg::SLOT_W-1:0]           slot,
    input  logic signed [tsd_pkg::SAMPLE_W-1:0]  sample,
    input  logic [tsd_pkg::FRAMES_W-1:0]         divisor,
    output tsd_pkg::lane_stats_t                 stats
);

    import tsd_pkg::*;

    localparam int ROW_W   = WINDOW_DEPTH * CORR_W;
    localparam int RECIP_W = SUM_W + 4;
    localparam int SHIFT   = SUM_W + 3;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);

    logic signed [ACC_W-1:0]    sums_reg    [TAXELS];
    logic signed [SAMPLE_W-1:0] offsets_reg [TAXELS];
    logic signed [CORR_W-1:0]   prev_reg    [TAXELS];
    logic [TAXELS-1:0]          row_valid_reg;

    logic signed [SUM_W-1:0]    sum_reg;
    logic                       neg_reg;
    logic [PROD_W-1:0]          prod_reg;
    lane_stats_t                stats_reg;

    logic                       div_neg_reg;
    logic [ACC_W-1:0]           quot_reg;
    logic [FRAMES_W-1:0]        rem_reg;

    logic [ROW_W-1:0]                     rd_data;
    logic [WINDOW_DEPTH-1:0][CORR_W-1:0]  row;
    logic [WINDOW_DEPTH-1:0][CORR_W-1:0]  new_row;
    logic signed [CORR_W-1:0]             diff;
    logic signed [SUM_W-1:0]              sum;
    logic [SUM_W-1:0]                     mag;
    logic [SUM_W-1:0]                     quo;
    logic signed [SUM_W:0]                mean_w;
    logic signed [CORR_W-1:0]             mean;
    logic signed [SLOPE_W-1:0]            slope;
    logic signed [ACC_W-1:0]              dividend;
    logic [FRAMES_W:0]                    trial;
    logic                                 ge;
    logic signed [ACC_W:0]                q_signed;
    logic signed [ACC_W:0]                q_sat;

    tsd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TAXELS)
    ) u_window (
        .clk   (clk),
        .we    (ctl.sum_en),
        .waddr (tx),
        .wdata (new_row),
        .re    (ctl.rd_en),
        .raddr (rd_tx),
        .rdata (rd_data)
    );

    always_comb
    begin
        row  = row_valid_reg[tx] ? rd_data : '0;
        diff = CORR_W'(sample) - CORR_W'(offsets_reg[tx]);
        sum  = '0;
        for (int j = 0; j < WINDOW_DEPTH; j++)
        begin
            new_row[j] = (slot == SLOT_W'(j)) ? diff : row[j];
            sum = sum + SUM_W'($signed(new_row[j]));
        end

        mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : sum_reg;
        quo    = prod_reg[SHIFT +: SUM_W];
        mean_w = neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        mean   = CORR_W'(mean_w);
        slope  = SLOPE_W'(mean) - SLOPE_W'(prev_reg[tx]);

        dividend = sums_reg[tx];
        trial    = {rem_reg, quot_reg[ACC_W-1]};
        ge       = trial >= {1'b0, divisor};
        q_signed = div_neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});
        if (q_signed > OFFSET_MAX)
        begin
            q_sat = OFFSET_MAX;
        end
        else if (q_signed < OFFSET_MIN)
        begin
            q_sat = OFFSET_MIN;
        end
        else
        begin
            q_sat = q_signed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TAXELS; t++)
            begin
                sums_reg[t]    <= '0;
                offsets_reg[t] <= '0;
                prev_reg[t]    <= '0;
            end
            row_valid_reg <= '0;
            stats_reg     <= '{peak: '0, low: LOW_SLOPE_RESET, high: HIGH_SLOPE_RESET};
        end
        else
        begin
            if (ctl.acc_en)
            begin
                sums_reg[tx] <= sums_reg[tx] + ACC_W'(sample);
            end
            if (ctl.sum_en)
            begin
                row_valid_reg[tx] <= 1'b1;
            end
            if (ctl.div_store)
            begin
                offsets_reg[tx] <= SAMPLE_W'(q_sat);
            end
            if (ctl.stats_en)
            begin
                prev_reg[tx] <= mean;
                if (mean > stats_reg.peak)
                begin
                    stats_reg.peak <= mean;
                end
                if (slope < stats_reg.low)
                begin
                    stats_reg.low <= slope;
                end
                if (slope > stats_reg.high)
                begin
                    stats_reg.high <= slope;
                end
            end
            else if (ctl.clear_en)
            begin
                stats_reg <= '{peak: '0, low: LOW_SLOPE_RESET, high: HIGH_SLOPE_RESET};
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
        begin
            sum_reg <= sum;
        end
        if (ctl.scale_en)
        begin
            neg_reg  <= sum_reg[SUM_W-1];
            prod_reg <= PROD_W'(mag) * PROD_W'(RECIP);
        end
        if (ctl.div_load)
        begin
            div_neg_reg <= dividend[ACC_W-1];
            quot_reg    <= dividend[ACC_W-1] ? ACC_W'(-dividend) : dividend;
            rem_reg     <= '0;
        end
        else if (ctl.div_step)
        begin
            rem_reg  <= ge ? FRAMES_W'(trial - {1'b0, divisor}) : trial[FRAMES_W-1:0];
            quot_reg <= {quot_reg[ACC_W-2:0], ge};
        end
    end

    assign stats = stats_reg;

endmodule

// ===== hw/rtl/tsd_merge.sv =====
// ----------------------------------------------------------------------------
// Tactile slip detector merge stage
// Combines both lanes' frame statistics into drive and amplitude levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsd_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tsd_pkg::lane_stats_t        right_stats,
    input  tsd_pkg::lane_stats_t        left_stats,
    input  logic [tsd_pkg::THR_W-1:0]   peak_limit,
    input  logic [tsd_pkg::THR_W-1:0]   slip_threshold,
    input  logic                        decide,
    input  logic                        commit,
    output tsd_pkg::tsd_levels_t        levels
);

    import tsd_pkg::*;

    tsd_levels_t levels_reg;
    logic [3:0]  right_dec;
    logic [3:0]  left_dec;

    function automatic logic [3:0] finger_levels(
        input lane_stats_t       st,
        input logic [1:0]        amp_now,
        input logic [THR_W-1:0]  amp_thr,
        input logic [THR_W-1:0]  slip_thr
    );
        logic [1:0]                amp;
        logic [1:0]                drive;
        logic signed [SLOPE_W:0]   thr;
        logic signed [SLOPE_W:0]   lo;
        logic signed [SLOPE_W:0]   hi;
        amp   = amp_now;
        drive = DRIVE_OFF;
        thr   = $signed({3'b000, slip_thr});
        lo    = (SLOPE_W + 1)'(st.low);
        hi    = (SLOPE_W + 1)'(st.high);
        if (SLOPE_W'(st.peak) > $signed({2'b00, amp_thr}))
        begin
            if (st.peak > 0 && st.peak <= BAND1_HIGH)
            begin
                amp = AMP_LOW;
            end
            if (st.peak > BAND2_LOW && st.peak <= BAND2_HIGH)
            begin
                amp = AMP_MID;
            end
            if (st.peak > BAND3_LOW && st.peak <= BAND3_HIGH)
            begin
                amp = AMP_HIGH;
            end
            if (lo < 0 && -lo > thr && hi > 0 && hi > thr)
            begin
                drive = DRIVE_PULSE;
            end
            else
            begin
                drive = DRIVE_ON;
            end
        end
        return {drive, amp};
    endfunction

    always_comb
    begin
        right_dec = finger_levels(right_stats, levels_reg.right_amplitude,
                                  peak_limit, slip_threshold);
        left_dec  = finger_levels(left_stats, levels_reg.left_amplitude,
                                  peak_limit, slip_threshold);
        if (decide)
        begin
            levels = '{right_drive: right_dec[3:2], right_amplitude: right_dec[1:0],
                       left_drive: left_dec[3:2], left_amplitude: left_dec[1:0]};
        end
        else
        begin
            levels = levels_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= '{right_drive: DRIVE_OFF, right_amplitude: AMP_MEDIUM,
                            left_drive: DRIVE_OFF, left_amplitude: AMP_MEDIUM};
        end
        else if (commit)
        begin
            levels_reg <= levels;
        end
    end

endmodule

// ===== hw/rtl/tactile_slip_detector.sv =====
// ----------------------------------------------------------------------------
// Tactile slip detector
// Two-finger pad calibration, windowed means and per-frame slip report.
// ----------------------------------------------------------------------------
// One sample transaction is taken at a time. While calibrating a taxel passes
// through the accept and accumulate steps; once calibrated it passes through
// accept, window row update and sum, reciprocal multiply for the mean, and
// slope and peak update; the two finger lanes run these steps in parallel.
// A frame end adds a frame step and an emit step, waiting in the emit step
// while a previous report is still stalled. The frame that completes
// calibration adds an offset sweep over every taxel by the bit-serial
// divider in each lane; no samples are taken during the sweep. Configuration
// writes are always taken. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module tactile_slip_detector #(
    parameter int TAXELS       = tsd_pkg::TAXELS_DEFAULT,
    parameter int WINDOW_DEPTH = tsd_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  tsd_pkg::tsd_sample_t               sample,
    output logic                               report_valid,
    input  logic                               report_stall,
    output tsd_pkg::tsd_report_t               report,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tsd_pkg::THR_W-1:0]          cfg_data
);

    import tsd_pkg::*;

    localparam int TW = (TAXELS > 1) ? $clog2(TAXELS) : 1;

    tsd_state_t           state_reg, state_next;
    tsd_sample_t          item_reg;
    logic                 ready_reg, ready_next;
    logic                 decide_reg, decide_next;
    logic [FRAMES_W-1:0]  frames_reg, frames_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [TW-1:0]        sweep_reg, sweep_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 report_valid_reg, report_valid_next;
    tsd_report_t          report_reg;
    logic [THR_W-1:0]     amp_thr_reg;
    logic [THR_W-1:0]     slip_thr_reg;
    logic [FRAMES_W-1:0]  cal_frames_reg;

    logic                 accept;
    logic                 in_range;
    logic                 item_in_range;
    logic                 emit;
    logic [FRAMES_W-1:0]  frames_inc;
    lane_ctl_t            ctl;
    logic [TW-1:0]        tx;
    logic [TW-1:0]        rd_tx;
    lane_stats_t          right_stats;
    lane_stats_t          left_stats;
    tsd_levels_t          levels;

    assign sample_stall  = (state_reg != ST_IDLE);
    assign accept        = sample_valid && !sample_stall;
    assign in_range      = 32'(sample.taxel_index) < TAXELS;
    assign item_in_range = 32'(item_reg.taxel_index) < TAXELS;
    assign rd_tx         = TW'(sample.taxel_index);
    assign tx            = (state_reg == ST_DIVIDE) ? sweep_reg : TW'(item_reg.taxel_index);
    assign frames_inc    = (frames_reg < FRAMES_MAX) ? frames_reg + 1'b1 : frames_reg;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        ready_next        = ready_reg;
        decide_next       = decide_reg;
        frames_next       = frames_reg;
        slot_next         = slot_reg;
        sweep_next        = sweep_reg;
        div_cnt_next      = div_cnt_reg;
        report_valid_next = report_valid_reg && report_stall;
        emit              = 1'b0;
        ctl               = '0;
        ctl.rd_en         = accept;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_range && ready_reg)
                    begin
                        state_next = ST_SUM;
                    end
                    else if (in_range)
                    begin
                        state_next = ST_ACC;
                    end
                    else if (sample.frame_last)
                    begin
                        state_next = ST_FRAME;
                    end
                end
            end
            ST_ACC:
            begin
                ctl.acc_en = 1'b1;
                state_next = item_reg.frame_last ? ST_FRAME : ST_IDLE;
            end
            ST_SUM:
            begin
                ctl.sum_en = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                ctl.scale_en = 1'b1;
                state_next   = ST_STATS;
            end
            ST_STATS:
            begin
                ctl.stats_en = item_in_range;
                state_next   = item_reg.frame_last ? ST_FRAME : ST_IDLE;
            end
            ST_FRAME:
            begin
                decide_next = ready_reg;
                state_next  = ST_EMIT;
                if (!ready_reg)
                begin
                    frames_next = frames_inc;
                    if (frames_inc >= cal_frames_reg)
                    begin
                        state_next   = ST_DIVIDE;
                        sweep_next   = '0;
                        div_cnt_next = DIV_LOAD;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_cnt_reg == DIV_LOAD)
                begin
                    ctl.div_load = 1'b1;
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
                else if (div_cnt_reg == DIV_STORE)
                begin
                    ctl.div_store = 1'b1;
                    div_cnt_next  = DIV_LOAD;
                    if (32'(sweep_reg) == TAXELS - 1)
                    begin
                        ready_next = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        sweep_next = sweep_reg + 1'b1;
                    end
                end
                else
                begin
                    ctl.div_step = 1'b1;
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!report_valid_reg || !report_stall)
                begin
                    emit              = 1'b1;
                    report_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                    if (decide_reg)
                    begin
                        ctl.clear_en = 1'b1;
                        slot_next = (32'(slot_reg) >= WINDOW_DEPTH - 1) ? '0
                                                                        : slot_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ready_reg        <= 1'b0;
            decide_reg       <= 1'b0;
            frames_reg       <= '0;
            slot_reg         <= '0;
            sweep_reg        <= '0;
            div_cnt_reg      <= DIV_LOAD;
            report_valid_reg <= 1'b0;
            amp_thr_reg      <= AMP_THR_RESET;
            slip_thr_reg     <= SLIP_THR_RESET;
            cal_frames_reg   <= CAL_FRAMES_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            ready_reg        <= ready_next;
            decide_reg       <= decide_next;
            frames_reg       <= frames_next;
            slot_reg         <= slot_next;
            sweep_reg        <= sweep_next;
            div_cnt_reg      <= div_cnt_next;
            report_valid_reg <= report_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_AMP_THRESHOLD:      amp_thr_reg    <= cfg_data;
                    REG_SLIP_THRESHOLD:     slip_thr_reg   <= cfg_data;
                    REG_CALIBRATION_FRAMES: cal_frames_reg <= cfg_data[FRAMES_W-1:0];
                    default:                ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= sample;
        end
        if (emit)
        begin
            report_reg <= '{calibrated: ready_reg,
                            right_drive: levels.right_drive,
                            right_amplitude: levels.right_amplitude,
                            left_drive: levels.left_drive,
                            left_amplitude: levels.left_amplitude};
        end
    end

    tsd_lane #(
        .TAXELS       (TAXELS),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_lane_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rd_tx   (rd_tx),
        .tx      (tx),
        .slot    (slot_reg),
        .sample  (item_reg.right_finger_sample),
        .divisor (frames_reg),
        .stats   (right_stats)
    );

    tsd_lane #(
        .TAXELS       (TAXELS),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_lane_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rd_tx   (rd_tx),
        .tx      (tx),
        .slot    (slot_reg),
        .sample  (item_reg.left_finger_sample),
        .divisor (frames_reg),
        .stats   (left_stats)
    );

    tsd_merge u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .right_stats    (right_stats),
        .left_stats     (left_stats),
        .peak_limit     (amp_thr_reg),
        .slip_threshold (slip_thr_reg),
        .decide         (decide_reg),
        .commit         (emit),
        .levels         (levels)
    );

    assign report_valid = report_valid_reg;
    assign report       = report_reg;

endmodule

// ===== hw/rtl/tsd_checker.sv =====
// ----------------------------------------------------------------------------
// Tactile slip detector checker
// Port-level checks on transactions and report contents, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tactile_slip_detector_defines.svh"

module tsd_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  report_valid,
    input logic                  report_stall,
    input tsd_pkg::tsd_report_t  report
);

    import tsd_pkg::*;

    `TSD_ASSERT_NEXT(a_report_held, report_valid && report_stall, report_valid, "report dropped while stalled")
    `TSD_ASSERT_NEXT(a_report_stable, report_valid && report_stall, $stable(report), "report changed while stalled")
    `TSD_ASSERT_NOW(a_idle_uncal, report_valid && !report.calibrated, report.right_drive == DRIVE_OFF && report.left_drive == DRIVE_OFF && report.right_amplitude == AMP_MEDIUM && report.left_amplitude == AMP_MEDIUM, "drive active before calibration")
    `TSD_ASSERT_NOW(a_drive_code, report_valid, report.right_drive != 2'd3 && report.left_drive != 2'd3, "undefined drive code")

endmodule

bind tactile_slip_detector tsd_checker u_tsd_checker (.*);

// ===== test/tb_tactile_slip_detector.sv =====
// ----------------------------------------------------------------------------
// Tactile slip detector testbench
// Drives sample transactions with random gaps against a random report stall,
// predicts every frame report in step with the block and compares it field
// by field. A directed table covers calibration, sample extremes and
// out-of-range taxels. Random frames follow under several threshold settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tactile_slip_detector;
    import tsd_pkg::*;

    localparam int NTAX = 22;
    localparam int WDEPTH = 5;

    typedef struct {
        tsd_sample_t it;
        bit          pinned;
        tsd_report_t exp;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    tsd_sample_t sample;
    logic        report_valid;
    logic        report_stall;
    tsd_report_t report;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [THR_W-1:0]       cfg_data;

    tactile_slip_detector u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predictor state
    int         amp_thr;
    int         slip_thr;
    int         cal_frames;
    int         cal_sums[2][NTAX];
    int         offsets[2][NTAX];
    int         win[2][NTAX][WDEPTH];
    int         prev_mean[2][NTAX];
    int         slot;
    int         frames_seen;
    bit         offsets_ready;
    int         peak[2];
    int         low_slope[2];
    int         high_slope[2];
    logic [1:0] amp_lv[2];
    logic [1:0] drv_lv[2];

    tsd_report_t report_q[$];
    bit          pin_q[$];
    tsd_report_t pin_exp_q[$];
    int          errors;
    int          reports_seen;
    bit          no_idle;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic clear_frame_stats();
        for (int f = 0; f < 2; f++)
        begin
            peak[f] = 0;
            low_slope[f] = 30000;
            high_slope[f] = -30000;
        end
    endtask

    task automatic take_taxel(int f, int t, int s);
        logic signed [ACC_W-1:0] wrapped;
        int sum;
        int mean;
        int d;
        sum = 0;
        if (!offsets_ready)
        begin
            wrapped = ACC_W'(cal_sums[f][t] + s);
            cal_sums[f][t] = 32'(wrapped);
            return;
        end
        win[f][t][slot] = s - offsets[f][t];
        for (int j = 0; j < WDEPTH; j++)
            sum += win[f][t][j];
        mean = sum / WDEPTH;
        d = mean - prev_mean[f][t];
        prev_mean[f][t] = mean;
        if (mean > peak[f]) peak[f] = mean;
        if (d < low_slope[f]) low_slope[f] = d;
        if (d > high_slope[f]) high_slope[f] = d;
    endtask

    task automatic decide_finger(int f);
        int lo;
        int hi;
        lo = low_slope[f];
        hi = high_slope[f];
        if (peak[f] > amp_thr)
        begin
            if (peak[f] > 0 && peak[f] <= 4000) amp_lv[f] = AMP_LOW;
            if (peak[f] > 4001 && peak[f] <= 6000) amp_lv[f] = AMP_MID;
            if (peak[f] > 8001 && peak[f] <= 12000) amp_lv[f] = AMP_HIGH;
            if (lo < 0 && -lo > slip_thr && hi > 0 && hi > slip_thr)
                drv_lv[f] = DRIVE_PULSE;
            else
                drv_lv[f] = DRIVE_ON;
        end
        else
            drv_lv[f] = DRIVE_OFF;
    endtask

    task automatic predict_report(tsd_sample_t it, output bit has, output tsd_report_t r);
        int n;
        int q;
        has = 1'b0;
        r = '0;
        if (it.taxel_index < NTAX)
        begin
            take_taxel(0, it.taxel_index, it.right_finger_sample);
            take_taxel(1, it.taxel_index, it.left_finger_sample);
        end
        if (!it.frame_last) return;
        if (!offsets_ready)
        begin
            if (frames_seen < 255) frames_seen++;
            if (frames_seen >= cal_frames)
            begin
                n = (frames_seen == 0) ? 1 : frames_seen;
                for (int f = 0; f < 2; f++)
                    for (int t = 0; t < NTAX; t++)
                    begin
                        q = cal_sums[f][t] / n;
                        if (q > 32767) q = 32767;
                        if (q < -32768) q = -32768;
                        offsets[f][t] = q;
                    end
                offsets_ready = 1'b1;
            end
        end
        else
        begin
            decide_finger(0);
            decide_finger(1);
            clear_frame_stats();
            slot = (slot + 1 >= WDEPTH) ? 0 : slot + 1;
        end
        has = 1'b1;
        r = {offsets_ready, drv_lv[0], amp_lv[0], drv_lv[1], amp_lv[1]};
    endtask

    // accepted sample transactions
    always @(posedge clk)
    begin
        bit has;
        bit pinned;
        tsd_report_t r;
        tsd_report_t pexp;
        if (rst_n && sample_valid && !sample_stall)
        begin
            predict_report(sample, has, r);
            pinned = pin_q.pop_front();
            pexp = pin_exp_q.pop_front();
            if (has) report_q.push_back(pinned ? pexp : r);
        end
    end

    // accepted report transactions
    always @(posedge clk)
    begin
        tsd_report_t e;
        if (rst_n && report_valid && !report_stall)
        begin
            reports_seen++;
            if (report_q.size() == 0)
            begin
                $display("%0t: unexpected report %h", $time, report);
                errors++;
            end
            else
            begin
                e = report_q.pop_front();
                if (report.calibrated !== e.calibrated)
                begin
                    $display("%0t: calibrated exp %0d got %0d", $time, e.calibrated,
                             report.calibrated);
                    errors++;
                end
                if (report.right_drive !== e.right_drive)
                begin
                    $display("%0t: right_drive exp %0d got %0d", $time, e.right_drive,
                             report.right_drive);
                    errors++;
                end
                if (report.right_amplitude !== e.right_amplitude)
                begin
                    $display("%0t: right_amplitude exp %0d got %0d", $time,
                             e.right_amplitude, report.right_amplitude);
                    errors++;
                end
                if (report.left_drive !== e.left_drive)
                begin
                    $display("%0t: left_drive exp %0d got %0d", $time, e.left_drive,
                             report.left_drive);
                    errors++;
                end
                if (report.left_amplitude !== e.left_amplitude)
                begin
                    $display("%0t: left_amplitude exp %0d got %0d", $time,
                             e.left_amplitude, report.left_amplitude);
                    errors++;
                end
            end
        end
    end

    // report stall, with one long hold-off once reports are flowing
    initial
    begin
        int hold;
        bit held;
        held = 1'b0;
        report_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && reports_seen >= 40)
            begin
                held = 1'b1;
                report_stall = 1'b1;
                for (hold = 0; hold < 400; hold++)
                    @(negedge clk);
            end
            if (no_idle || $urandom_range(0, 99) < 70)
                report_stall = 1'b0;
            else if ($urandom_range(0, 99) < 90)
                report_stall = 1'b1;
            else
            begin
                report_stall = 1'b1;
                repeat ($urandom_range(10, 40)) @(negedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 70) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_sample(tsd_sample_t it, bit pinned, tsd_report_t exp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            sample_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pin_q.push_back(pinned);
        pin_exp_q.push_back(exp);
        sample_valid = 1'b1;
        sample = it;
        do @(posedge clk); while (sample_stall);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
        @(negedge clk);
        sample_valid = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = THR_W'(value);
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_AMP_THRESHOLD:      amp_thr = value & 16'hFFFF;
            REG_SLIP_THRESHOLD:     slip_thr = value & 16'hFFFF;
            REG_CALIBRATION_FRAMES: cal_frames = value & 8'hFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        sample_valid = 1'b0;
        wait (report_q.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [15:0] near_offset(int off);
        int v;
        v = off + $urandom_range(0, 16000) - 2000;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    task automatic random_frames(int count);
        tsd_sample_t it;
        int len;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            len = $urandom_range(1, 30);
            no_idle = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    it.taxel_index = INDEX_W'($urandom_range(22, 31));
                else
                    it.taxel_index = INDEX_W'($urandom_range(0, NTAX - 1));
                if (it.taxel_index < NTAX && $urandom_range(0, 3) != 0)
                begin
                    it.right_finger_sample = near_offset(offsets[0][it.taxel_index]);
                    it.left_finger_sample = near_offset(offsets[1][it.taxel_index]);
                end
                else
                begin
                    it.right_finger_sample = SAMPLE_W'($urandom);
                    it.left_finger_sample = SAMPLE_W'($urandom);
                end
                it.frame_last = (k == len - 1);
                send_sample(it, 1'b0, '0);
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        #4_000_000;
        $display("[tactile_slip_detector] ERROR");
        $finish;
    end

    initial
    begin
        dir_row_t tab[$];
        tsd_report_t cal0;
        tsd_report_t cal1;
        cal0 = {1'b0, DRIVE_OFF, AMP_MEDIUM, DRIVE_OFF, AMP_MEDIUM};
        cal1 = {1'b1, DRIVE_OFF, AMP_MEDIUM, DRIVE_OFF, AMP_MEDIUM};

        amp_thr = 2000;
        slip_thr = 75;
        cal_frames = 20;
        foreach (cal_sums[f, t])
        begin
            cal_sums[f][t] = 0;
            offsets[f][t] = 0;
            prev_mean[f][t] = 0;
            for (int j = 0; j < WDEPTH; j++) win[f][t][j] = 0;
        end
        slot = 0;
        frames_seen = 0;
        offsets_ready = 1'b0;
        clear_frame_stats();
        amp_lv = '{AMP_MEDIUM, AMP_MEDIUM};
        drv_lv = '{DRIVE_OFF, DRIVE_OFF};
        errors = 0;
        reports_seen = 0;
        no_idle = 1'b0;

        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_AMP_THRESHOLD;
        cfg_data = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        write_reg(REG_AMP_THRESHOLD, 0);
        write_reg(REG_SLIP_THRESHOLD, 0);
        write_reg(REG_CALIBRATION_FRAMES, 2);

        // calibration, two frames, extremes and an out-of-range taxel
        tab.push_back('{'{5'd0, 16'sh7FFF, 16'sh8000, 1'b0}, 1'b0, '0});
        tab.push_back('{'{5'd21, 16'sh8000, 16'sh7FFF, 1'b0}, 1'b0, '0});
        tab.push_back('{'{5'd31, 16'sh1234, 16'shFFFF, 1'b1}, 1'b1, cal0});
        tab.push_back('{'{5'd0, 16'sh7FFF, 16'sh8000, 1'b0}, 1'b0, '0});
        tab.push_back('{'{5'd21, 16'sh8000, 16'sh7FFF, 1'b0}, 1'b0, '0});
        tab.push_back('{'{5'd1, 16'sd100, 16'sd200, 1'b1}, 1'b1, cal1});
        // calibrated frames: rise, fall for slip, repeated taxel, extremes
        tab.push_back('{'{5'd1, 16'sd20050, 16'sd30100, 1'b0}, 1'b0, '0});
        tab.push_back('{'{5'd0, 16'sh7FFF, 16'sh8000, 1'b1}, 1'b0, '0});
        tab.push_back('{'{5'd1, 16'sd50, 16'sd100, 1'b0}, 1'b0, '0});
        tab.push_back('{'{5'd2, 16'sd30000, 16'sd25000, 1'b0}, 1'b0, '0});
        tab.push_back('{'{5'd2, 16'sd31000, 16'sd26000, 1'b1}, 1'b0, '0});
        tab.push_back('{'{5'd21, 16'sh8000, 16'sh7FFF, 1'b0}, 1'b0, '0});
        tab.push_back('{'{5'd16, 16'sh7FFF, 16'sh8000, 1'b0}, 1'b0, '0});
        tab.push_back('{'{5'd8, 16'sh8000, 16'sh7FFF, 1'b0}, 1'b0, '0});
        tab.push_back('{'{5'd22, 16'sh5555, 16'shAAAA, 1'b1}, 1'b0, '0});
        tab.push_back('{'{5'd3, 16'sd5000, 16'sd9000, 1'b1}, 1'b0, '0});
        tab.push_back('{'{5'd4, -16'sd5000, 16'sd60, 1'b1}, 1'b0, '0});
        tab.push_back('{'{5'd31, 16'sd0, 16'sd0, 1'b1}, 1'b0, '0});
        foreach (tab[i])
            send_sample(tab[i].it, tab[i].pinned, tab[i].exp);

        random_frames(500);
        wait_idle();
        write_reg(REG_AMP_THRESHOLD, 65535);
        write_reg(REG_SLIP_THRESHOLD, 65535);
        write_reg(REG_CALIBRATION_FRAMES, 255);
        random_frames(250);
        wait_idle();
        write_reg(REG_AMP_THRESHOLD, $urandom_range(0, 3000));
        write_reg(REG_SLIP_THRESHOLD, $urandom_range(0, 200));
        write_reg(REG_CALIBRATION_FRAMES, 1);
        random_frames(400);
        wait_idle();
        write_reg(REG_AMP_THRESHOLD, 2000);
        write_reg(REG_SLIP_THRESHOLD, 75);
        random_frames(450);

        @(negedge clk);
        sample_valid = 1'b0;
        wait (report_q.size() == 0);
        repeat (40) @(negedge clk);
        if (errors == 0)
            $display("[tactile_slip_detector] OK");
        else
            $display("[tactile_slip_detector] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tsd_pkg.sv
hw/rtl/tsd_ram.sv
hw/rtl/tsd_lane.sv
hw/rtl/tsd_merge.sv
hw/rtl/tactile_slip_detector.sv
hw/rtl/tsd_checker.sv
test/tb_tactile_slip_detector.sv
